[rtl/wpee_pkg.sv]
// Shared widths, constants, command and status types of the progress ETA estimator.
`default_nettype none

package wpee_pkg;

    // Field widths
    localparam int TIME_W  = 63;
    localparam int PROG_W  = 17;
    localparam int BYTES_W = 48;
    localparam int SPEED_W = 48;
    localparam int RATE_W  = 48;

    // Stream word widths, padded to whole bytes
    localparam int IN_DATA_W  = ((TIME_W + PROG_W + BYTES_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RATE_W + TIME_W + 7) / 8) * 8;

    // Window
    localparam int WINDOW_SAMPLES = 100;
    localparam int MIN_SAMPLES    = 5;
    localparam int RING_DEPTH     = WINDOW_SAMPLES - 1;
    localparam int HEAD_W         = $clog2(RING_DEPTH);
    localparam int CNT_W          = $clog2(WINDOW_SAMPLES + 1);
    localparam int SUM_W          = SPEED_W + $clog2(RING_DEPTH + 1);

    // Q formats
    localparam int                SPEED_SHIFT  = 32;
    localparam logic [PROG_W-1:0] PROGRESS_ONE = PROG_W'(65536);
    localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};
    localparam logic [RATE_W-1:0] RATE_MAX     = {RATE_W{1'b1}};

    // Serial divider
    localparam int DIV_W      = 64;
    localparam int DVS_W      = TIME_W;
    localparam int DIV_STEP_W = $clog2(DIV_W + 1);
    localparam int SPD_STEPS  = PROG_W + SPEED_SHIFT;

    // Rate multiply
    localparam longint unsigned USEC_PER_SEC = 64'd1000000;
    localparam longint unsigned RATE_Q_LIMIT = ((64'd1 << RATE_W) - 64'd1) / USEC_PER_SEC;
    localparam int HALF_W  = SPEED_W / 2;
    localparam int ACC_W   = BYTES_W + SPEED_W;
    localparam int Q_W     = ACC_W - SPEED_W;
    localparam int QM_W    = $clog2(RATE_Q_LIMIT + 1);
    localparam int MUL_A_W = (QM_W > HALF_W) ? QM_W : HALF_W;
    localparam int MUL_B_W = HALF_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int USEC_W  = 20;
    localparam int FRAC_W  = USEC_W + 1;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_TAKE,
        DP_FIRST,
        DP_SPD_START,
        DP_COMMIT,
        DP_AVG_START,
        DP_AVG_LATCH,
        DP_END_START,
        DP_END_LATCH,
        DP_MUL_LL,
        DP_MUL_LH,
        DP_MUL_HL,
        DP_MUL_HH,
        DP_MUL_RL,
        DP_MUL_RH,
        DP_MUL_Q,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_ge_min;
        logic div_busy;
        logic avg_zero;
        logic out_free;
    } t_dp_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SPD_WAIT,
        ST_CHECK,
        ST_AVG_WAIT,
        ST_END_CHK,
        ST_END_WAIT,
        ST_MUL_LL,
        ST_MUL_LH,
        ST_MUL_HL,
        ST_MUL_HH,
        ST_MUL_RL,
        ST_MUL_RH,
        ST_MUL_Q,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

[rtl/wpee_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, dividend aligned to the top.
`default_nettype none

module wpee_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [wpee_pkg::DIV_W-1:0]      i_dividend,
    input  wire logic [wpee_pkg::DVS_W-1:0]      i_divisor,
    input  wire logic [wpee_pkg::DIV_STEP_W-1:0] i_steps,
    output logic                                  o_busy,
    output logic      [wpee_pkg::DIV_W-1:0]      o_quotient
);

    logic [wpee_pkg::DIV_W-1:0]      r_num;
    logic [wpee_pkg::DIV_W-1:0]      r_quo;
    logic [wpee_pkg::DVS_W-1:0]      r_rem;
    logic [wpee_pkg::DVS_W-1:0]      r_div;
    logic [wpee_pkg::DIV_STEP_W-1:0] r_steps;
    logic                            r_busy;

    logic [wpee_pkg::DVS_W:0]   trial;
    logic [wpee_pkg::DVS_W:0]   diff;
    logic                       ge;
    logic [wpee_pkg::DVS_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_num[wpee_pkg::DIV_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = trial >= {1'b0, r_div};
        // remainder stays below the divisor, so the top bit drops
        n_rem = ge ? diff[wpee_pkg::DVS_W-1:0] : trial[wpee_pkg::DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_steps <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_steps <= i_steps;
        end else if (r_busy) begin
            r_steps <= r_steps - 1'b1;
            if (r_steps == wpee_pkg::DIV_STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[wpee_pkg::DIV_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[wpee_pkg::DIV_W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

[rtl/wpee_dp.sv]
// Datapath: report registers, speed ring and sum, shared divider, rate multiplier, output word.
`default_nettype none

module wpee_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire wpee_pkg::t_dp_cmd             i_cmd,
    output wpee_pkg::t_dp_stat                 o_stat,
    input  wire logic [wpee_pkg::TIME_W-1:0]  i_in_time,
    input  wire logic [wpee_pkg::PROG_W-1:0]  i_in_prog,
    input  wire logic [wpee_pkg::BYTES_W-1:0] i_in_bytes,
    input  wire logic                          i_m_ready,
    output logic                               o_m_valid,
    output logic      [wpee_pkg::RATE_W-1:0]  o_rate,
    output logic      [wpee_pkg::TIME_W-1:0]  o_end,
    output logic                               o_flag
);

    // Report under work
    logic [wpee_pkg::TIME_W-1:0]  r_in_time;
    logic [wpee_pkg::PROG_W-1:0]  r_in_prog;
    logic [wpee_pkg::BYTES_W-1:0] r_in_bytes;

    // Window state
    logic [wpee_pkg::TIME_W-1:0]  r_last_time;
    logic [wpee_pkg::PROG_W-1:0]  r_last_prog;
    logic [wpee_pkg::SUM_W-1:0]   r_sum;
    logic [wpee_pkg::CNT_W-1:0]   r_count;
    logic [wpee_pkg::HEAD_W-1:0]  r_head;
    logic [wpee_pkg::SPEED_W-1:0] r_ring [wpee_pkg::RING_DEPTH];
    logic [wpee_pkg::SPEED_W-1:0] r_old;

    // Estimate
    logic [wpee_pkg::SPEED_W-1:0] r_avg;
    logic [wpee_pkg::TIME_W-1:0]  r_end;
    logic                         r_flag;
    logic [wpee_pkg::PROD_W-1:0]  r_prod;
    logic [wpee_pkg::ACC_W-1:0]   r_acc;
    logic [wpee_pkg::USEC_W-1:0]  r_tmp;
    logic [wpee_pkg::FRAC_W-1:0]  r_frac;

    // Output word
    logic                         r_out_valid;
    logic [wpee_pkg::RATE_W-1:0]  r_out_rate;
    logic [wpee_pkg::TIME_W-1:0]  r_out_end;
    logic                         r_out_flag;

    wpee_pkg::t_dp_op op;
    logic [wpee_pkg::PROG_W-1:0]     in_prog_c;
    logic [wpee_pkg::PROG_W-1:0]     dprog;
    logic                            time_fwd;
    logic [wpee_pkg::SPEED_W-1:0]    speed;
    logic                            window_full;
    logic [wpee_pkg::SUM_W-1:0]      n_sum;
    logic [wpee_pkg::CNT_W-1:0]      n_count;
    logic [wpee_pkg::HEAD_W-1:0]     n_head;
    logic [wpee_pkg::CNT_W-1:0]      count_m1;
    logic [wpee_pkg::PROG_W-1:0]     rem_prog;
    logic [wpee_pkg::TIME_W:0]       end_sum;
    logic [wpee_pkg::TIME_W-1:0]     n_end;

    logic                            div_start;
    logic [wpee_pkg::DIV_W-1:0]      div_dividend;
    logic [wpee_pkg::DVS_W-1:0]      div_divisor;
    logic [wpee_pkg::DIV_STEP_W-1:0] div_steps;
    logic                            div_busy;
    logic [wpee_pkg::DIV_W-1:0]      div_quo;

    logic [wpee_pkg::MUL_A_W-1:0]    mul_a;
    logic [wpee_pkg::MUL_B_W-1:0]    mul_b;
    logic [wpee_pkg::PROD_W-1:0]     mul_p;
    logic [wpee_pkg::PROD_W:0]       frac_sum;
    logic [wpee_pkg::PROD_W:0]       rate_sum;
    logic [wpee_pkg::RATE_W-1:0]     n_rate;

    assign op = i_cmd.op;

    always_comb begin
        in_prog_c   = (i_in_prog > wpee_pkg::PROGRESS_ONE) ? wpee_pkg::PROGRESS_ONE : i_in_prog;
        dprog       = (r_in_prog > r_last_prog) ? (r_in_prog - r_last_prog) : '0;
        time_fwd    = r_in_time > r_last_time;
        // zero or backward gap gives speed 0; overflow saturates
        if (!time_fwd) begin
            speed = '0;
        end else if (|div_quo[wpee_pkg::DIV_W-1:wpee_pkg::SPEED_W]) begin
            speed = wpee_pkg::RATE_MAX;
        end else begin
            speed = div_quo[wpee_pkg::SPEED_W-1:0];
        end
        window_full = r_count == wpee_pkg::CNT_W'(wpee_pkg::WINDOW_SAMPLES);
        n_sum       = r_sum - (window_full ? wpee_pkg::SUM_W'(r_old) : '0)
                      + wpee_pkg::SUM_W'(speed);
        n_count     = window_full ? r_count : r_count + 1'b1;
        n_head      = (r_head == wpee_pkg::HEAD_W'(wpee_pkg::RING_DEPTH - 1)) ? '0
                      : r_head + 1'b1;
        count_m1    = r_count - 1'b1;
        rem_prog    = wpee_pkg::PROGRESS_ONE - r_in_prog;
        end_sum     = {1'b0, r_in_time}
                      + (wpee_pkg::TIME_W + 1)'(div_quo[wpee_pkg::SPD_STEPS-1:0]);
        if (r_avg == '0 || end_sum[wpee_pkg::TIME_W]) begin
            n_end = wpee_pkg::TIME_MAX;
        end else begin
            n_end = end_sum[wpee_pkg::TIME_W-1:0];
        end
    end

    // Divider operand select
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        div_steps    = '0;
        case (op)
            wpee_pkg::DP_SPD_START: begin
                div_start    = 1'b1;
                div_dividend = wpee_pkg::DIV_W'(dprog) << (wpee_pkg::DIV_W - wpee_pkg::PROG_W);
                div_divisor  = r_in_time - r_last_time;
                div_steps    = wpee_pkg::DIV_STEP_W'(wpee_pkg::SPD_STEPS);
            end
            wpee_pkg::DP_AVG_START: begin
                div_start    = 1'b1;
                div_dividend = wpee_pkg::DIV_W'(r_sum) << (wpee_pkg::DIV_W - wpee_pkg::SUM_W);
                div_divisor  = wpee_pkg::DVS_W'(count_m1);
                div_steps    = wpee_pkg::DIV_STEP_W'(wpee_pkg::SUM_W);
            end
            wpee_pkg::DP_END_START: begin
                div_start    = 1'b1;
                div_dividend = wpee_pkg::DIV_W'(rem_prog)
                               << (wpee_pkg::DIV_W - wpee_pkg::PROG_W);
                div_divisor  = wpee_pkg::DVS_W'(r_avg);
                div_steps    = wpee_pkg::DIV_STEP_W'(wpee_pkg::SPD_STEPS);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    wpee_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // Multiplier operand select: four partials of bytes * avg, then the 10^6 scaling
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            wpee_pkg::DP_MUL_LL: begin
                mul_a = wpee_pkg::MUL_A_W'(r_in_bytes[wpee_pkg::HALF_W-1:0]);
                mul_b = r_avg[wpee_pkg::HALF_W-1:0];
            end
            wpee_pkg::DP_MUL_LH: begin
                mul_a = wpee_pkg::MUL_A_W'(r_in_bytes[wpee_pkg::HALF_W-1:0]);
                mul_b = r_avg[wpee_pkg::SPEED_W-1:wpee_pkg::HALF_W];
            end
            wpee_pkg::DP_MUL_HL: begin
                mul_a = wpee_pkg::MUL_A_W'(r_in_bytes[wpee_pkg::BYTES_W-1:wpee_pkg::HALF_W]);
                mul_b = r_avg[wpee_pkg::HALF_W-1:0];
            end
            wpee_pkg::DP_MUL_HH: begin
                mul_a = wpee_pkg::MUL_A_W'(r_in_bytes[wpee_pkg::BYTES_W-1:wpee_pkg::HALF_W]);
                mul_b = r_avg[wpee_pkg::SPEED_W-1:wpee_pkg::HALF_W];
            end
            wpee_pkg::DP_MUL_RL: begin
                mul_a = wpee_pkg::MUL_A_W'(r_acc[wpee_pkg::HALF_W-1:0]);
                mul_b = wpee_pkg::MUL_B_W'(wpee_pkg::USEC_PER_SEC);
            end
            wpee_pkg::DP_MUL_RH: begin
                mul_a = wpee_pkg::MUL_A_W'(r_acc[wpee_pkg::SPEED_W-1:wpee_pkg::HALF_W]);
                mul_b = wpee_pkg::MUL_B_W'(wpee_pkg::USEC_PER_SEC);
            end
            wpee_pkg::DP_MUL_Q: begin
                mul_a = wpee_pkg::MUL_A_W'(r_acc[wpee_pkg::SPEED_W +: wpee_pkg::QM_W]);
                mul_b = wpee_pkg::MUL_B_W'(wpee_pkg::USEC_PER_SEC);
            end
            default: begin
                mul_a = '0;
            end
        endcase
        mul_p = wpee_pkg::PROD_W'(mul_a) * wpee_pkg::PROD_W'(mul_b);
    end

    always_comb begin
        frac_sum = {1'b0, r_prod} + (wpee_pkg::PROD_W + 1)'(r_tmp);
        rate_sum = {1'b0, r_prod} + (wpee_pkg::PROD_W + 1)'(r_frac);
        if (r_in_bytes == '0) begin
            n_rate = '0;
        end else if (r_acc[wpee_pkg::ACC_W-1:wpee_pkg::SPEED_W]
                     > wpee_pkg::Q_W'(wpee_pkg::RATE_Q_LIMIT)) begin
            n_rate = wpee_pkg::RATE_MAX;
        end else if (rate_sum > (wpee_pkg::PROD_W + 1)'(wpee_pkg::RATE_MAX)) begin
            n_rate = wpee_pkg::RATE_MAX;
        end else begin
            n_rate = rate_sum[wpee_pkg::RATE_W-1:0];
        end
    end

    // Window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_last_prog <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_head      <= '0;
        end else begin
            case (op)
                wpee_pkg::DP_FIRST: begin
                    r_count     <= wpee_pkg::CNT_W'(1);
                    r_last_time <= r_in_time;
                    r_last_prog <= r_in_prog;
                end
                wpee_pkg::DP_COMMIT: begin
                    r_sum       <= n_sum;
                    r_count     <= n_count;
                    r_head      <= n_head;
                    r_last_time <= r_in_time;
                    r_last_prog <= r_in_prog;
                end
                default: begin
                    r_head <= r_head;
                end
            endcase
        end
    end

    // Speed ring
    always_ff @(posedge i_clk) begin
        if (op == wpee_pkg::DP_COMMIT) begin
            r_ring[r_head] <= speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == wpee_pkg::DP_SPD_START) begin
            r_old <= r_ring[r_head];
        end
    end

    // Report and estimate registers
    always_ff @(posedge i_clk) begin
        case (op)
            wpee_pkg::DP_TAKE: begin
                r_in_time  <= i_in_time;
                r_in_prog  <= in_prog_c;
                r_in_bytes <= i_in_bytes;
            end
            wpee_pkg::DP_AVG_LATCH: begin
                r_avg <= div_quo[wpee_pkg::SPEED_W-1:0];
            end
            wpee_pkg::DP_END_LATCH: begin
                r_end  <= n_end;
                r_flag <= r_avg == '0;
            end
            wpee_pkg::DP_MUL_LL: begin
                r_prod <= mul_p;
            end
            wpee_pkg::DP_MUL_LH: begin
                r_acc  <= wpee_pkg::ACC_W'(r_prod);
                r_prod <= mul_p;
            end
            wpee_pkg::DP_MUL_HL, wpee_pkg::DP_MUL_HH: begin
                r_acc  <= r_acc + (wpee_pkg::ACC_W'(r_prod) << wpee_pkg::HALF_W);
                r_prod <= mul_p;
            end
            wpee_pkg::DP_MUL_RL: begin
                // low half of the product is final here
                r_acc  <= r_acc + (wpee_pkg::ACC_W'(r_prod) << (2 * wpee_pkg::HALF_W));
                r_prod <= mul_p;
            end
            wpee_pkg::DP_MUL_RH: begin
                r_tmp  <= r_prod[wpee_pkg::HALF_W +: wpee_pkg::USEC_W];
                r_prod <= mul_p;
            end
            wpee_pkg::DP_MUL_Q: begin
                r_frac <= frac_sum[wpee_pkg::HALF_W +: wpee_pkg::FRAC_W];
                r_prod <= mul_p;
            end
            default: begin
                r_flag <= r_flag;
            end
        endcase
    end

    // Output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (op == wpee_pkg::DP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == wpee_pkg::DP_OUT) begin
            r_out_rate <= n_rate;
            r_out_end  <= r_end;
            r_out_flag <= r_flag;
        end
    end

    always_comb begin
        o_stat.count_zero   = r_count == '0;
        o_stat.count_ge_min = r_count >= wpee_pkg::CNT_W'(wpee_pkg::MIN_SAMPLES);
        o_stat.div_busy     = div_busy;
        o_stat.avg_zero     = r_avg == '0;
        o_stat.out_free     = !r_out_valid || i_m_ready;
    end

    assign o_m_valid = r_out_valid;
    assign o_rate    = r_out_rate;
    assign o_end     = r_out_end;
    assign o_flag    = r_out_flag;

endmodule

`default_nettype wire

[rtl/wpee_ctrl.sv]
// Controller: enable register and the sequencer that steps the datapath through one report.
`default_nettype none

module wpee_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_wr_data,
    input  wire logic               i_s_valid,
    output logic                    o_s_ready,
    input  wire wpee_pkg::t_dp_stat i_stat,
    output wpee_pkg::t_dp_cmd       o_cmd
);

    wpee_pkg::t_state r_state;
    wpee_pkg::t_state n_state;
    logic             r_enable;
    logic             accept;

    assign accept = i_s_valid && (r_state == wpee_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_enable <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wpee_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wpee_pkg::ST_IDLE: begin
                // drop the word when estimation is off
                if (accept && r_enable) begin
                    n_state = wpee_pkg::ST_LOAD;
                end
            end
            wpee_pkg::ST_LOAD: begin
                n_state = i_stat.count_zero ? wpee_pkg::ST_IDLE : wpee_pkg::ST_SPD_WAIT;
            end
            wpee_pkg::ST_SPD_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = wpee_pkg::ST_CHECK;
                end
            end
            wpee_pkg::ST_CHECK: begin
                n_state = i_stat.count_ge_min ? wpee_pkg::ST_AVG_WAIT : wpee_pkg::ST_IDLE;
            end
            wpee_pkg::ST_AVG_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = wpee_pkg::ST_END_CHK;
                end
            end
            wpee_pkg::ST_END_CHK: begin
                n_state = i_stat.avg_zero ? wpee_pkg::ST_MUL_LL : wpee_pkg::ST_END_WAIT;
            end
            wpee_pkg::ST_END_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = wpee_pkg::ST_MUL_LL;
                end
            end
            wpee_pkg::ST_MUL_LL: n_state = wpee_pkg::ST_MUL_LH;
            wpee_pkg::ST_MUL_LH: n_state = wpee_pkg::ST_MUL_HL;
            wpee_pkg::ST_MUL_HL: n_state = wpee_pkg::ST_MUL_HH;
            wpee_pkg::ST_MUL_HH: n_state = wpee_pkg::ST_MUL_RL;
            wpee_pkg::ST_MUL_RL: n_state = wpee_pkg::ST_MUL_RH;
            wpee_pkg::ST_MUL_RH: n_state = wpee_pkg::ST_MUL_Q;
            wpee_pkg::ST_MUL_Q:  n_state = wpee_pkg::ST_OUT;
            wpee_pkg::ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = wpee_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wpee_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_ready = r_state == wpee_pkg::ST_IDLE;
        o_cmd.op  = wpee_pkg::DP_NOP;
        case (r_state)
            wpee_pkg::ST_IDLE: begin
                if (accept && r_enable) begin
                    o_cmd.op = wpee_pkg::DP_TAKE;
                end
            end
            wpee_pkg::ST_LOAD: begin
                o_cmd.op = i_stat.count_zero ? wpee_pkg::DP_FIRST : wpee_pkg::DP_SPD_START;
            end
            wpee_pkg::ST_SPD_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = wpee_pkg::DP_COMMIT;
                end
            end
            wpee_pkg::ST_CHECK: begin
                if (i_stat.count_ge_min) begin
                    o_cmd.op = wpee_pkg::DP_AVG_START;
                end
            end
            wpee_pkg::ST_AVG_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = wpee_pkg::DP_AVG_LATCH;
                end
            end
            wpee_pkg::ST_END_CHK: begin
                o_cmd.op = i_stat.avg_zero ? wpee_pkg::DP_END_LATCH : wpee_pkg::DP_END_START;
            end
            wpee_pkg::ST_END_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = wpee_pkg::DP_END_LATCH;
                end
            end
            wpee_pkg::ST_MUL_LL: o_cmd.op = wpee_pkg::DP_MUL_LL;
            wpee_pkg::ST_MUL_LH: o_cmd.op = wpee_pkg::DP_MUL_LH;
            wpee_pkg::ST_MUL_HL: o_cmd.op = wpee_pkg::DP_MUL_HL;
            wpee_pkg::ST_MUL_HH: o_cmd.op = wpee_pkg::DP_MUL_HH;
            wpee_pkg::ST_MUL_RL: o_cmd.op = wpee_pkg::DP_MUL_RL;
            wpee_pkg::ST_MUL_RH: o_cmd.op = wpee_pkg::DP_MUL_RH;
            wpee_pkg::ST_MUL_Q:  o_cmd.op = wpee_pkg::DP_MUL_Q;
            wpee_pkg::ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = wpee_pkg::DP_OUT;
                end
            end
            default: begin
                o_cmd.op = wpee_pkg::DP_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/windowed_progress_eta_estimator.sv]
// Top level of the windowed progress speed and completion time estimator.
//
//  channel   dir   handshake                     payload (low bit up)
//  config    in    i_cfg_wr_en                   i_cfg_wr_data: estimate_enable
//  reports   in    s_axis_tvalid/s_axis_tready   report_usec, progress, total_bytes
//  results   out   m_axis_tvalid/m_axis_tready   rate_bytes_per_sec, expected_end_usec;
//                                                tuser: no_progress_flag
//
//  A first report only seeds the window, a report before the window holds enough samples
//  only adds its speed, and a later one gives a result: one shared radix-2 divider runs
//  the interval speed (49 steps), the mean (55 steps) and, for a nonzero mean, the time
//  left (49 steps); then a 29x24 multiplier forms bytes * mean and the 10^6 scaling.
//  A new report is taken only in idle; a pending result waits in its own register.
//  Reset clears the window state and the enable; ring entries are read only once written.
`default_nettype none

module windowed_progress_eta_estimator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic                                i_cfg_wr_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // report_usec [62:0], progress [79:63], total_bytes [127:80]
    input  wire logic [wpee_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // rate_bytes_per_sec [47:0], expected_end_usec [110:48], zero pad [111]
    output logic      [wpee_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // no_progress_flag [0]
    output logic      [0:0]                          m_axis_tuser
);

    localparam int PROG_LO  = wpee_pkg::TIME_W;
    localparam int BYTES_LO = wpee_pkg::TIME_W + wpee_pkg::PROG_W;
    localparam int PAD_W    = wpee_pkg::OUT_DATA_W - wpee_pkg::RATE_W - wpee_pkg::TIME_W;

    wpee_pkg::t_dp_cmd  cmd;
    wpee_pkg::t_dp_stat stat;

    logic [wpee_pkg::RATE_W-1:0] out_rate;
    logic [wpee_pkg::TIME_W-1:0] out_end;
    logic                        out_flag;

    wpee_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_valid     (s_axis_tvalid),
        .o_s_ready     (s_axis_tready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    wpee_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in_time  (s_axis_tdata[wpee_pkg::TIME_W-1:0]),
        .i_in_prog  (s_axis_tdata[PROG_LO +: wpee_pkg::PROG_W]),
        .i_in_bytes (s_axis_tdata[BYTES_LO +: wpee_pkg::BYTES_W]),
        .i_m_ready  (m_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_rate     (out_rate),
        .o_end      (out_end),
        .o_flag     (out_flag)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, out_end, out_rate};
    assign m_axis_tuser = out_flag;

endmodule

`default_nettype wire
